// File: hdl/trsmq_pkg.sv
// ----------------------------------------------------------------------------
// trsmq_pkg
// Types, widths and arithmetic helpers shared by the TRS matrix pipeline.
// ----------------------------------------------------------------------------
package trsmq_pkg;

    // Field and intermediate widths
    localparam int FIX_W  = 32;   // Q16.16 position, scale and matrix entries
    localparam int QUAT_W = 16;   // Q2.14 quaternion components
    localparam int PROD_W = 32;   // Q4.28 quaternion products
    localparam int R28_W  = 34;   // rotation entry in Q.28 before rounding
    localparam int ROT_W  = 30;   // rotation entry rounded to Q.24
    localparam int MUL_W  = ROT_W + FIX_W;   // Q.40 rotation times scale
    localparam int RND_W  = MUL_W - 24;      // product after the Q.40 to Q.16 shift

    typedef logic signed [FIX_W-1:0]  fix_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [R28_W-1:0]  r28_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef logic signed [MUL_W-1:0]  mul_t;
    typedef logic signed [RND_W-1:0]  rnd_t;

    // Slots of the quaternion product vector
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    // Constants
    localparam r28_t R28_ONE   = 34'sd268435456;   // 1.0 in Q.28
    localparam r28_t R28_HALF  = 34'sd8;           // half an LSB of Q.24
    localparam mul_t MUL_HALF  = 62'sd8388608;     // half an LSB of Q.16 in Q.40
    localparam rnd_t FIX_MAX_R = 38'sd2147483647;
    localparam rnd_t FIX_MIN_R = -38'sd2147483648;

    // One input item
    typedef struct packed {
        fix_t  pos_x;
        fix_t  pos_y;
        fix_t  pos_z;
        quat_t quat_w;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        fix_t  scale_x;
        fix_t  scale_y;
        fix_t  scale_z;
    } in_t;

    // After the product stage
    typedef struct packed {
        fix_t  [2:0] pos;
        fix_t  [2:0] scl;
        prod_t [8:0] prod;
    } prod_stage_t;

    // After the rotation stage: rot is row-major, rot[3*r+c]
    typedef struct packed {
        fix_t [2:0] pos;
        fix_t [2:0] scl;
        rot_t [8:0] rot;
    } rot_stage_t;

    // After the scale multiply
    typedef struct packed {
        fix_t [2:0] pos;
        mul_t [8:0] prd;
    } mul_stage_t;

    // Top three rows of the model matrix, m[4*r+c]
    typedef struct packed {
        fix_t [11:0] m;
    } mat_t;

    // Sign-extend a product to the Q.28 entry width
    function automatic r28_t ext_r28(input prod_t p);
        return {{(R28_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // Round Q.28 to Q.24, halves toward plus infinity
    function automatic rot_t round_r24(input r28_t r);
        r28_t t;
        t = r + R28_HALF;
        return t[R28_W-1:4];
    endfunction

    // Round Q.40 to Q16.16 and saturate to 32 bits
    function automatic fix_t round_sat(input mul_t p);
        mul_t t;
        rnd_t q;
        t = p + MUL_HALF;
        q = t[MUL_W-1:24];
        if (q > FIX_MAX_R)
            return FIX_MAX_R[FIX_W-1:0];
        else if (q < FIX_MIN_R)
            return FIX_MIN_R[FIX_W-1:0];
        else
            return q[FIX_W-1:0];
    endfunction

endpackage

// File: hdl/trsmq_in_if.sv
// ----------------------------------------------------------------------------
// trsmq_in_if
// Input channel: translation, quaternion and scale of one transform.
// ----------------------------------------------------------------------------
interface trsmq_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  pos_x;
    logic signed [31:0]  pos_y;
    logic signed [31:0]  pos_z;
    logic signed [15:0]  quat_w;
    logic signed [15:0]  quat_x;
    logic signed [15:0]  quat_y;
    logic signed [15:0]  quat_z;
    logic signed [31:0]  scale_x;
    logic signed [31:0]  scale_y;
    logic signed [31:0]  scale_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
               scale_x, scale_y, scale_z,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
               scale_x, scale_y, scale_z,
        output ready
    );
endinterface

// File: hdl/trsmq_out_if.sv
// ----------------------------------------------------------------------------
// trsmq_out_if
// Output channel: top three rows of the model matrix, Q16.16.
// ----------------------------------------------------------------------------
interface trsmq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m03;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m23;

    modport source (
        output valid, m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23,
        input  ready
    );

    modport sink (
        input  valid, m00, m01, m02, m03, m10, m11, m12, m13, m20, m21, m22, m23,
        output ready
    );
endinterface

// File: hdl/trsmq_prod.sv
// ----------------------------------------------------------------------------
// trsmq_prod
// Stage 1: the nine quaternion products in Q4.28, registered.
// ----------------------------------------------------------------------------
module trsmq_prod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  trsmq_pkg::in_t           in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output trsmq_pkg::prod_stage_t   out_data
);
    import trsmq_pkg::*;

    logic        vld_reg;
    prod_stage_t data_reg;
    prod_stage_t data_next;

    // Stage takes an item when empty or when downstream drains it
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // Form products and pass translation and scale along
    always_comb
    begin
        data_next.pos[0]    = in_data.pos_x;
        data_next.pos[1]    = in_data.pos_y;
        data_next.pos[2]    = in_data.pos_z;
        data_next.scl[0]    = in_data.scale_x;
        data_next.scl[1]    = in_data.scale_y;
        data_next.scl[2]    = in_data.scale_z;
        data_next.prod[P_XX] = prod_t'(in_data.quat_x) * prod_t'(in_data.quat_x);
        data_next.prod[P_YY] = prod_t'(in_data.quat_y) * prod_t'(in_data.quat_y);
        data_next.prod[P_ZZ] = prod_t'(in_data.quat_z) * prod_t'(in_data.quat_z);
        data_next.prod[P_XY] = prod_t'(in_data.quat_x) * prod_t'(in_data.quat_y);
        data_next.prod[P_XZ] = prod_t'(in_data.quat_x) * prod_t'(in_data.quat_z);
        data_next.prod[P_YZ] = prod_t'(in_data.quat_y) * prod_t'(in_data.quat_z);
        data_next.prod[P_WX] = prod_t'(in_data.quat_w) * prod_t'(in_data.quat_x);
        data_next.prod[P_WY] = prod_t'(in_data.quat_w) * prod_t'(in_data.quat_y);
        data_next.prod[P_WZ] = prod_t'(in_data.quat_w) * prod_t'(in_data.quat_z);
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end
endmodule

// File: hdl/trsmq_rot.sv
// ----------------------------------------------------------------------------
// trsmq_rot
// Stage 2: rotation matrix entries in Q.28, rounded to Q.24, registered.
// ----------------------------------------------------------------------------
module trsmq_rot (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  trsmq_pkg::prod_stage_t   in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output trsmq_pkg::rot_stage_t    out_data
);
    import trsmq_pkg::*;

    logic        vld_reg;
    rot_stage_t  data_reg;
    rot_stage_t  data_next;
    r28_t [8:0]  r28;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    // Expand the quaternion into the rotation part, row-major
    always_comb
    begin
        r28[0] = R28_ONE - ((ext_r28(in_data.prod[P_YY]) + ext_r28(in_data.prod[P_ZZ])) <<< 1);
        r28[1] = (ext_r28(in_data.prod[P_XY]) - ext_r28(in_data.prod[P_WZ])) <<< 1;
        r28[2] = (ext_r28(in_data.prod[P_XZ]) + ext_r28(in_data.prod[P_WY])) <<< 1;
        r28[3] = (ext_r28(in_data.prod[P_XY]) + ext_r28(in_data.prod[P_WZ])) <<< 1;
        r28[4] = R28_ONE - ((ext_r28(in_data.prod[P_XX]) + ext_r28(in_data.prod[P_ZZ])) <<< 1);
        r28[5] = (ext_r28(in_data.prod[P_YZ]) - ext_r28(in_data.prod[P_WX])) <<< 1;
        r28[6] = (ext_r28(in_data.prod[P_XZ]) - ext_r28(in_data.prod[P_WY])) <<< 1;
        r28[7] = (ext_r28(in_data.prod[P_YZ]) + ext_r28(in_data.prod[P_WX])) <<< 1;
        r28[8] = R28_ONE - ((ext_r28(in_data.prod[P_XX]) + ext_r28(in_data.prod[P_YY])) <<< 1);
    end

    // Round entries to Q.24 and pass translation and scale along
    always_comb
    begin
        data_next.pos = in_data.pos;
        data_next.scl = in_data.scl;
        for (int i = 0; i < 9; i++)
        begin
            data_next.rot[i] = round_r24(r28[i]);
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end
endmodule

// File: hdl/trsmq_scale.sv
// ----------------------------------------------------------------------------
// trsmq_scale
// Stages 3 and 4: rotation entry times column scale, then round, saturate
// and assemble the output matrix in the output register.
// ----------------------------------------------------------------------------
module trsmq_scale (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  trsmq_pkg::rot_stage_t    in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output trsmq_pkg::mat_t          out_data
);
    import trsmq_pkg::*;

    logic        mul_vld_reg;
    mul_stage_t  mul_reg;
    mul_stage_t  mul_next;
    logic        mul_ready;
    logic        out_vld_reg;
    mat_t        out_reg;
    mat_t        out_next;
    logic        out_ready_int;

    // Ready chain through the two stages
    assign out_ready_int = !out_vld_reg || out_ready;
    assign mul_ready     = !mul_vld_reg || out_ready_int;
    assign in_ready      = mul_ready;
    assign out_valid     = out_vld_reg;
    assign out_data      = out_reg;

    // Multiply each entry by the scale of its column
    always_comb
    begin
        mul_next.pos = in_data.pos;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mul_next.prd[3*r+c] = mul_t'(in_data.rot[3*r+c]) * mul_t'(in_data.scl[c]);
            end
        end
    end

    // Round, saturate and place translation in column 3
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_next.m[4*r+c] = round_sat(mul_reg.prd[3*r+c]);
            end
            out_next.m[4*r+3] = mul_reg.pos[r];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (mul_ready)
                mul_vld_reg <= in_valid;
            if (out_ready_int)
                out_vld_reg <= mul_vld_reg;
        end
    end

    // Load payloads on accept
    always_ff @(posedge clk)
    begin
        if (mul_ready && in_valid)
            mul_reg <= mul_next;
        if (out_ready_int && mul_vld_reg)
            out_reg <= out_next;
    end
endmodule

// File: hdl/trs_matrix_from_quaternion_unit.sv
// Throughput: one item per cycle while the output channel is not stalled;
// each of the four stages holds one item and moves it on when the stage
// after it is empty or draining.
// Stages: quaternion products, rotation entries, scale multiply, round/saturate.
// Reset: rst_n clears all stage valid bits at once; payload is not reset.
// ----------------------------------------------------------------------------
// trs_matrix_from_quaternion_unit
// Top three rows of the T*R*S model matrix from translation, quaternion
// and per-axis scale, in fixed point.
// ----------------------------------------------------------------------------
module trs_matrix_from_quaternion_unit (
    input  logic       clk,
    input  logic       rst_n,
    trsmq_in_if.sink   in_ch,
    trsmq_out_if.source out_ch
);
    import trsmq_pkg::*;

    in_t         in_data;
    logic        prod_valid;
    logic        prod_ready;
    prod_stage_t prod_data;
    logic        rot_valid;
    logic        rot_ready;
    rot_stage_t  rot_data;
    mat_t        mat;

    // Gather the input item
    assign in_data.pos_x   = in_ch.pos_x;
    assign in_data.pos_y   = in_ch.pos_y;
    assign in_data.pos_z   = in_ch.pos_z;
    assign in_data.quat_w  = in_ch.quat_w;
    assign in_data.quat_x  = in_ch.quat_x;
    assign in_data.quat_y  = in_ch.quat_y;
    assign in_data.quat_z  = in_ch.quat_z;
    assign in_data.scale_x = in_ch.scale_x;
    assign in_data.scale_y = in_ch.scale_y;
    assign in_data.scale_z = in_ch.scale_z;

    trsmq_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    trsmq_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    trsmq_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (mat)
    );

    // Spread the matrix onto the output item
    assign out_ch.m00 = mat.m[0];
    assign out_ch.m01 = mat.m[1];
    assign out_ch.m02 = mat.m[2];
    assign out_ch.m03 = mat.m[3];
    assign out_ch.m10 = mat.m[4];
    assign out_ch.m11 = mat.m[5];
    assign out_ch.m12 = mat.m[6];
    assign out_ch.m13 = mat.m[7];
    assign out_ch.m20 = mat.m[8];
    assign out_ch.m21 = mat.m[9];
    assign out_ch.m22 = mat.m[10];
    assign out_ch.m23 = mat.m[11];
endmodule

// File: hdl/trsmq_checker.sv
// ----------------------------------------------------------------------------
// trsmq_checker
// Port-level checks on the TRS matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module trsmq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] m03,
    input logic signed [31:0] m13
);
    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    // Keep a stalled result's payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(m03) && $stable(m13))
        else $error("stalled output item changed");

    // Input backpressure only when every stage is full and the output is stalled
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with room in the pipeline");

    // Without stalls an accepted item reaches the output with its translation
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc, 4) && $past(rst_n, 1) && $past(rst_n, 2) &&
        $past(rst_n, 3) && $past(rst_n, 4) && $past(out_ready, 1) &&
        $past(out_ready, 2) && $past(out_ready, 3)
        |-> out_valid && m03 == $past(pos_x, 4) && m13 == $past(pos_y, 4))
        else $error("item late or translation corrupted");
endmodule

bind trs_matrix_from_quaternion_unit trsmq_checker u_trsmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .m03       (out_ch.m03),
    .m13       (out_ch.m13)
);
